// ===== rtl/core/mhfc_pkg.sv =====
// Package of the hourglass force correction block: item types, codes,
// derived widths and small helper functions.
// Used by every module of the block; depends on nothing.
package mhfc_pkg;

  localparam int FRAC_BITS = 16;
  // Width of a signed row mismatch: three shifted products plus a position.
  localparam int EW = 67 - FRAC_BITS;
  // Width of the force magnitude after the final product is scaled back.
  localparam int MGW = 63 - FRAC_BITS;
  localparam int SQ_STEPS = 32;
  localparam int DIV_STEPS = 31;
  localparam int Q_DEPTH = 2;

  typedef enum logic [1:0] {
    ACT_LOAD_POS = 2'd0,
    ACT_LOAD_ROW = 2'd1,
    ACT_PAIR     = 2'd2
  } action_e;

  localparam logic REG_GAIN = 1'b0;
  localparam logic REG_3D   = 1'b1;

  typedef struct packed {
    logic [1:0]         action;
    logic [1:0]         row_index;
    logic signed [31:0] cur_x;
    logic signed [31:0] cur_y;
    logic signed [31:0] cur_z;
    logic signed [31:0] ref_x;
    logic signed [31:0] ref_y;
    logic signed [31:0] ref_z;
    logic [16:0]        weight;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] force_dx;
    logic signed [31:0] force_dy;
    logic signed [31:0] force_dz;
    logic               degenerate;
  } out_item_t;

  // One queued pair: offsets, the matrix seen at acceptance and the weight.
  typedef struct packed {
    logic [2:0][31:0] d;
    logic [2:0][31:0] d0;
    logic [8:0][31:0] mat;
    logic [16:0]      weight;
  } pair_t;

  function automatic logic [31:0] sat_sub(input logic [31:0] a, input logic [31:0] b);
    logic signed [32:0] v;
    v = $signed({a[31], a}) - $signed({b[31], b});
    if (v[32] != v[31]) begin
      return v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    return v[31:0];
  endfunction

endpackage

// ===== rtl/core/meshfree_hourglass_force_correction.sv =====
// Top level of the hourglass force correction block: configuration
// registers, front part, pair queue and back pipeline.
// Depends on mhfc_pkg, mhfc_front, mhfc_fifo and mhfc_back.
//
// Usage: items arrive on the in channel (valid/ready). Load items set the
// material point positions or one row of the deformation increment and
// give no result; a pair item gives one result item on the out channel.
// The front part takes one item per cycle while the two-entry pair queue
// has room. The back pipeline takes one pair per cycle while the receiver
// is not stalling: products, sum, a 32-stage square root, a 31-stage
// divider for each axis, scaling and the output register. Sustained
// throughput is one item per cycle while results are taken.
// When the receiver stalls, the whole back pipeline holds; the queue then
// fills and in_ready_o drops after two more pairs. Load items also wait
// while the queue is full.
// Reset clears the pipeline valids and the queue, sets the gain to 0 and
// selects 3-D mode. The point positions and matrix hold nothing useful
// until loaded. Configuration writes take effect at once; the user must
// make them only while the block is idle, which the block does not enforce.
module meshfree_hourglass_force_correction import mhfc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [30:0] cfg_wdata_i
);

  logic [30:0] gain_q;
  logic        three_d_q;
  logic        q_full, q_empty, q_push, q_pop;
  pair_t       q_in, q_head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q    <= '0;
      three_d_q <= 1'b1;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_GAIN) begin
        gain_q <= cfg_wdata_i;
      end
      if (cfg_idx_i == REG_3D) begin
        three_d_q <= cfg_wdata_i[0];
      end
    end
  end

  mhfc_front u_front (
    .clk_i      (clk_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_in)
  );

  mhfc_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_in),
    .pop_i       (q_pop),
    .full_o      (q_full),
    .empty_o     (q_empty),
    .head_o      (q_head)
  );

  mhfc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .gain_i      (gain_q),
    .three_d_i   (three_d_q),
    .q_empty_i   (q_empty),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/core/mhfc_fifo.sv =====
// Short queue of pair items between the front and back parts.
// Depends on mhfc_pkg for the entry type and depth.
module mhfc_fifo import mhfc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  pair_t push_data_i,
  input  logic  pop_i,
  output logic  full_o,
  output logic  empty_o,
  output pair_t head_o
);

  localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CW = $clog2(Q_DEPTH + 1);

  pair_t          mem_q [Q_DEPTH];
  logic [PW-1:0]  wp_q, wp_d, rp_q, rp_d;
  logic [CW-1:0]  cnt_q, cnt_d;

  assign full_o  = (cnt_q == CW'(Q_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rp_q];

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wp_d = (wp_q == PW'(Q_DEPTH - 1)) ? '0 : wp_q + 1'b1;
    end
    if (pop_i) begin
      rp_d = (rp_q == PW'(Q_DEPTH - 1)) ? '0 : rp_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/core/mhfc_front.sv =====
// Front part: accepts items, applies loads to the stored material point and
// matrix, and forms the offsets of pair items for the queue. Depends on mhfc_pkg.
module mhfc_front import mhfc_pkg::*; (
  input  logic     clk_i,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_data_i,
  input  logic     q_full_i,
  output logic     q_push_o,
  output pair_t    q_data_o
);

  logic [2:0][31:0] pcur_q, pref_q;
  logic [8:0][31:0] mat_q;
  logic [2:0][31:0] cur_w, ref_w;
  logic             accept;

  assign cur_w = {in_data_i.cur_z, in_data_i.cur_y, in_data_i.cur_x};
  assign ref_w = {in_data_i.ref_z, in_data_i.ref_y, in_data_i.ref_x};

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign q_push_o   = accept && (in_data_i.action == ACT_PAIR);

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      q_data_o.d[c]  = sat_sub(cur_w[c], pcur_q[c]);
      q_data_o.d0[c] = sat_sub(ref_w[c], pref_q[c]);
    end
    q_data_o.mat    = mat_q;
    q_data_o.weight = in_data_i.weight;
  end

  // The stored point has no reset; load items must write it before use, unchecked.
  always_ff @(posedge clk_i) begin
    if (accept && in_data_i.action == ACT_LOAD_POS) begin
      pcur_q <= cur_w;
      pref_q <= ref_w;
    end
    if (accept && in_data_i.action == ACT_LOAD_ROW) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          if (in_data_i.row_index == 2'(r)) begin
            mat_q[3*r+c] <= cur_w[c];
          end
        end
      end
    end
  end

endmodule

// ===== rtl/core/mhfc_back.sv =====
// Back part: pipelined products, square root, per-axis division and force
// scaling, with the output register. Depends on mhfc_pkg.
module mhfc_back import mhfc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [30:0] gain_i,
  input  logic        three_d_i,
  input  logic        q_empty_i,
  input  pair_t       q_head_i,
  output logic        q_pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o
);

  typedef struct packed {
    logic               vld;
    logic               dg;
    logic [31:0]        g16;
    logic [2:0]         pos;
    logic [2:0][EW-1:0] ae;
  } sq_side_t;

  typedef struct packed {
    logic             vld;
    logic             dg;
    logic [31:0]      g16;
    logic [2:0]       pos;
    logic [31:0]      norm;
    logic [2:0]       ovf;
    logic [2:0][30:0] nl;
    logic [2:0][31:0] rem;
    logic [2:0][30:0] q;
  } dv_t;

  logic adv;

  // Stage A: products.
  logic             a_vld_q;
  logic [8:0][63:0] a_prod_q;
  logic [2:0][63:0] a_sq_q;
  logic [2:0][31:0] a_d_q;
  logic [31:0]      a_g16_q;
  logic [47:0]      gw;

  // Square root and division pipelines.
  sq_side_t    sqs_q [SQ_STEPS+1];
  logic [63:0] sqn_q [SQ_STEPS+1];
  logic [63:0] sqr_q [SQ_STEPS+1];
  sq_side_t    b_side;
  logic [63:0] b_n2;
  dv_t         dv_q [DIV_STEPS+1];
  dv_t         dv_init;

  // Scale stage and output.
  logic                m_vld_q, m_dg_q;
  logic [2:0]          m_pos_q;
  logic [2:0][MGW-1:0] m_mag_q;
  logic                out_vld_q;
  out_item_t           out_q, out_d;

  assign adv         = !out_vld_q || out_ready_i;
  assign q_pop_o     = adv && !q_empty_i;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  assign gw = gain_i * q_head_i.weight;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (adv) begin
      a_vld_q <= !q_empty_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 9; i++) begin
        a_prod_q[i] <= $signed(q_head_i.mat[i]) * $signed(q_head_i.d0[i%3]);
      end
      for (int c = 0; c < 3; c++) begin
        a_sq_q[c] <= $signed(q_head_i.d0[c]) * $signed(q_head_i.d0[c]);
      end
      a_d_q   <= q_head_i.d;
      a_g16_q <= gw[47:16];
    end
  end

  // Stage B: mapped offset, mismatch and squared length. In 2-D mode the
  // third column drops out of every row.
  always_comb begin
    logic signed [EW-1:0] acc;
    logic signed [EW-1:0] e;
    logic signed [63:0]   term;
    b_side.vld = a_vld_q;
    b_side.g16 = a_g16_q;
    for (int r = 0; r < 3; r++) begin
      acc = '0;
      for (int c = 0; c < 3; c++) begin
        term = $signed(a_prod_q[3*r+c]) >>> FRAC_BITS;
        if (three_d_i || c < 2) begin
          acc = acc + term[EW-1:0];
        end
      end
      e = EW'($signed(a_d_q[r])) - acc;
      b_side.ae[r]  = e[EW-1] ? -e : e;
      b_side.pos[r] = !e[EW-1] && (e != '0);
    end
    b_n2 = a_sq_q[0] + a_sq_q[1] + (three_d_i ? a_sq_q[2] : 64'd0);
    b_side.dg = (b_n2 == 64'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sqs_q[0].vld <= 1'b0;
    end else if (adv) begin
      sqs_q[0] <= b_side;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sqn_q[0] <= b_n2;
      sqr_q[0] <= 64'd0;
    end
  end

  // One result bit of the integer square root per stage.
  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    localparam logic [63:0] BITV = 64'd1 << (62 - 2 * k);
    logic [63:0] t, n_d, r_d;

    always_comb begin
      t = sqr_q[k] + BITV;
      if (sqn_q[k] >= t) begin
        n_d = sqn_q[k] - t;
        r_d = (sqr_q[k] >> 1) + BITV;
      end else begin
        n_d = sqn_q[k];
        r_d = sqr_q[k] >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sqs_q[k+1].vld <= 1'b0;
      end else if (adv) begin
        sqs_q[k+1] <= sqs_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sqn_q[k+1] <= n_d;
        sqr_q[k+1] <= r_d;
      end
    end
  end

  // Division setup: a quotient of 2^31 or more saturates, otherwise the
  // leading part of the scaled mismatch is already below the norm.
  always_comb begin
    logic [EW-1:0]           sh;
    logic [EW+FRAC_BITS-1:0] nfull;
    dv_init.vld  = sqs_q[SQ_STEPS].vld;
    dv_init.dg   = sqs_q[SQ_STEPS].dg;
    dv_init.g16  = sqs_q[SQ_STEPS].g16;
    dv_init.pos  = sqs_q[SQ_STEPS].pos;
    dv_init.norm = sqr_q[SQ_STEPS][31:0];
    for (int c = 0; c < 3; c++) begin
      sh             = sqs_q[SQ_STEPS].ae[c] >> (31 - FRAC_BITS);
      nfull          = {sqs_q[SQ_STEPS].ae[c], {FRAC_BITS{1'b0}}};
      dv_init.ovf[c] = (sh >= EW'(dv_init.norm));
      dv_init.rem[c] = sh[31:0];
      dv_init.nl[c]  = nfull[30:0];
      dv_init.q[c]   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0].vld <= 1'b0;
    end else if (adv) begin
      dv_q[0] <= dv_init;
    end
  end

  // One quotient bit per axis per stage, most significant first.
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    dv_t dv_d;

    always_comb begin
      logic [32:0] t;
      dv_d = dv_q[j];
      for (int c = 0; c < 3; c++) begin
        t = {dv_q[j].rem[c], dv_q[j].nl[c][DIV_STEPS-1-j]};
        if (t >= {1'b0, dv_q[j].norm}) begin
          dv_d.rem[c]                = 32'(t - {1'b0, dv_q[j].norm});
          dv_d.q[c][DIV_STEPS-1-j]   = 1'b1;
        end else begin
          dv_d.rem[c] = t[31:0];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[j+1].vld <= 1'b0;
      end else if (adv) begin
        dv_q[j+1] <= dv_d;
      end
    end
  end

  // Scale stage: gain term times the error magnitude.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else if (adv) begin
      m_vld_q <= dv_q[DIV_STEPS].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    logic [30:0] errmag;
    logic [62:0] prod;
    if (adv) begin
      m_dg_q  <= dv_q[DIV_STEPS].dg;
      m_pos_q <= dv_q[DIV_STEPS].pos;
      for (int c = 0; c < 3; c++) begin
        errmag     = dv_q[DIV_STEPS].ovf[c] ? 31'h7FFF_FFFF : dv_q[DIV_STEPS].q[c];
        prod       = dv_q[DIV_STEPS].g16 * errmag;
        m_mag_q[c] <= prod[62:FRAC_BITS];
      end
    end
  end

  // Output stage: sign opposite to the error, saturated to 32 bits; all zero if degenerate, z zero in 2-D.
  always_comb begin
    logic [2:0][31:0] f;
    for (int c = 0; c < 3; c++) begin
      if (m_pos_q[c]) begin
        f[c] = (m_mag_q[c] >= MGW'(33'h0_8000_0000)) ? 32'h8000_0000
                                                     : 32'(-m_mag_q[c][31:0]);
      end else begin
        f[c] = (m_mag_q[c] >= MGW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : m_mag_q[c][31:0];
      end
    end
    if (!three_d_i) begin
      f[2] = '0;
    end
    if (m_dg_q) begin
      f = '0;
    end
    out_d.force_dx   = f[0];
    out_d.force_dy   = f[1];
    out_d.force_dz   = f[2];
    out_d.degenerate = m_dg_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= m_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.degenerate |->
      out_q.force_dx == '0 && out_q.force_dy == '0 && out_q.force_dz == '0)
    else $error("degenerate result with nonzero force");

  a_two_d_z: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !three_d_i |-> out_q.force_dz == '0)
    else $error("z force nonzero in 2-D mode");

  a_norm_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_q[0].vld |-> (dv_q[0].dg == (dv_q[0].norm == '0)))
    else $error("square root disagrees with degenerate flag");

endmodule
